// ----- design/array_stack_with_peek_core_defines.svh -----
// Assertion macros shared by the stack core.
// Expects i_clk and i_rst_n in the including scope.
`ifndef ARRAY_STACK_WITH_PEEK_CORE_DEFINES_SVH
`define ARRAY_STACK_WITH_PEEK_CORE_DEFINES_SVH

// same-cycle implication
`define ASP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/asp_pkg.sv -----
// Types and codes for the LIFO stack core.
// No dependencies.
`default_nettype none

package asp_pkg;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPOS    = 2'd3;

    // largest count the 4-bit capacity register allows
    localparam int CAP_MAX = 15;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [31:0] push_value;
        logic        [3:0]  position;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic signed [31:0] top_value;
        logic signed [31:0] bottom_value;
        logic        [3:0]  entry_count;
        logic               is_empty;
        logic               is_full;
        logic        [1:0]  status;
    } t_out_word;

endpackage

`default_nettype wire

// ----- design/asp_cell.sv -----
// One stack cell: holds a word, takes its upper neighbor's word on push
// and its lower neighbor's word on pop. Depends on asp_pkg.
`default_nettype none

module asp_cell (
    input  wire                   i_clk,
    input  wire asp_pkg::t_cell_op i_op,
    input  wire logic signed [31:0] i_from_up,
    input  wire logic signed [31:0] i_from_down,
    output logic signed [31:0]    o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        unique case (i_op)
            asp_pkg::CELL_PUSH: n_data = i_from_up;
            asp_pkg::CELL_POP:  n_data = i_from_down;
            default:            n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ----- design/array_stack_with_peek_core.sv -----
// Top level of the bounded LIFO stack with peek.
// Depends on asp_pkg, asp_cell and array_stack_with_peek_core_defines.svh.
`default_nettype none

// The stack is a row of shifting cells with the top in cell 0. A new word is
// accepted every cycle while input is not stalled. The result word appears in
// the output register in the cycle after acceptance, and input is stalled
// only while that register is full and stalled downstream.
// The count never exceeds the smaller of DEPTH and 15, the largest capacity
// the 4-bit capacity register can ask for, so only that many cells are built.
module array_stack_with_peek_core #(
    parameter int DEPTH = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire asp_pkg::t_in_word i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output asp_pkg::t_out_word  o_out_word,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [3:0]     i_cfg_data
);

    `include "array_stack_with_peek_core_defines.svh"

    localparam int NCELL = (DEPTH < asp_pkg::CAP_MAX) ? DEPTH : asp_pkg::CAP_MAX;
    localparam int CW    = $clog2(NCELL + 1);
    localparam logic [3:0] NCELL4 = 4'(NCELL);

    logic [3:0]          r_cap;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    asp_pkg::t_out_word  r_out_word;
    asp_pkg::t_out_word  n_out_word;

    logic signed [31:0]  cell_data [NCELL];
    asp_pkg::t_cell_op   cell_op;

    logic                in_accept;
    logic                cfg_accept;
    logic [3:0]          eff_cap;
    logic [3:0]          cnt4;
    logic [3:0]          n_cnt4;
    logic                full;
    logic [3:0]          peek_idx;
    logic [3:0]          bot_idx;
    logic signed [31:0]  peek_word;
    logic signed [31:0]  bot_word;
    logic                ovf_push;
    logic                out_none;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid & o_cfg_ready;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    assign eff_cap = (r_cap == 4'd0) ? 4'd1 : ((r_cap > NCELL4) ? NCELL4 : r_cap);
    assign cnt4    = 4'(r_count);
    assign full    = cnt4 >= eff_cap;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            logic signed [31:0] from_up;
            logic signed [31:0] from_down;
            if (g == 0) begin : g_first
                assign from_up = i_in_word.push_value;
            end else begin : g_mid
                assign from_up = cell_data[g-1];
            end
            if (g == NCELL - 1) begin : g_last
                assign from_down = '0;
            end else begin : g_inner
                assign from_down = cell_data[g+1];
            end
            asp_cell u_cell (
                .i_clk       (i_clk),
                .i_op        (cell_op),
                .i_from_up   (from_up),
                .i_from_down (from_down),
                .o_data      (cell_data[g])
            );
        end
    endgenerate

    // cell selects: peek reads position-1, bottom reads count-1
    assign peek_idx = i_in_word.position - 4'd1;
    assign bot_idx  = cnt4 - 4'd1;

    always_comb begin
        peek_word = '0;
        bot_word  = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (peek_idx == 4'(i)) peek_word = cell_data[i];
            if (bot_idx == 4'(i))  bot_word  = cell_data[i];
        end
    end

    always_comb begin
        cell_op    = asp_pkg::CELL_HOLD;
        n_count    = r_count;
        n_out_word = '0;
        unique case (i_in_word.kind)
            asp_pkg::KIND_PUSH: begin
                if (full) begin
                    n_out_word.status = asp_pkg::ST_OVERFLOW;
                end else begin
                    cell_op = asp_pkg::CELL_PUSH;
                    n_count = r_count + CW'(1);
                end
            end
            asp_pkg::KIND_POP: begin
                if (r_count == '0) begin
                    n_out_word.status = asp_pkg::ST_UNDERFLOW;
                end else begin
                    cell_op                = asp_pkg::CELL_POP;
                    n_count                = r_count - CW'(1);
                    n_out_word.read_value  = cell_data[0];
                end
            end
            asp_pkg::KIND_PEEK: begin
                if (i_in_word.position == 4'd0 || i_in_word.position > cnt4) begin
                    n_out_word.status = asp_pkg::ST_BADPOS;
                end else begin
                    n_out_word.read_value = peek_word;
                end
            end
            default: begin
            end
        endcase
        if (!in_accept) begin
            cell_op = asp_pkg::CELL_HOLD;
        end

        n_cnt4 = 4'(n_count);
        if (n_count == '0) begin
            n_out_word.top_value    = '0;
            n_out_word.bottom_value = '0;
        end else begin
            unique case (cell_op)
                asp_pkg::CELL_PUSH: n_out_word.top_value = i_in_word.push_value;
                asp_pkg::CELL_POP:  n_out_word.top_value = cell_data[1];
                default:            n_out_word.top_value = cell_data[0];
            endcase
            n_out_word.bottom_value = (r_count == '0) ? i_in_word.push_value : bot_word;
        end
        n_out_word.entry_count = n_cnt4;
        n_out_word.is_empty    = (n_count == '0);
        n_out_word.is_full     = n_cnt4 >= eff_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= 4'd8;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_accept) begin
                r_cap <= i_cfg_data;
            end
            if (in_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign ovf_push = in_accept && (i_in_word.kind == asp_pkg::KIND_PUSH) && full;
    assign out_none = (r_out_word.entry_count == 4'd0);

    `ASP_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(NCELL), "count beyond cell row")
    `ASP_ASSERT_NEXT(a_overflow_keeps, ovf_push, $stable(r_count), "overflow changed count")
    `ASP_ASSERT_NEXT(a_result_follows, in_accept, r_out_valid, "accepted word left no result")
    `ASP_ASSERT_NOW(a_empty_flag, r_out_valid, r_out_word.is_empty == out_none, "empty flag wrong")

endmodule

`default_nettype wire
